@@ sv/plst_pkg.sv @@
// package for the positional list store: widths, command and status codes
`timescale 1ns / 1ps
`default_nettype none
package plst_pkg;

  // default list capacity
  localparam int unsigned DEPTH = 64;

  // word field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT_AT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_APPEND     = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

endpackage
`default_nettype wire

@@ sv/positional_list_store_core.sv @@
// positional list store: ordered list in a single memory, shifted one entry at a time
// sequence: an error goes straight to the done state; an insert moves each entry at or above its slot
//   up one slot, then places the new word; a pop captures the front entry, then moves the rest down one
// throughput: one word at a time; each moved entry costs a read state and a write state on the
//   one-port-per-direction element memory, stepped by a single +/-1 address unit
// reset: rst_ni clears the count, sequencer and output valid; the element memory is not cleared
// a finished result sits in the output register, so a new word is taken while it waits
`timescale 1ns / 1ps
`default_nettype none
module positional_list_store_core #(
  parameter int unsigned DEPTH = plst_pkg::DEPTH
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // command channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [plst_pkg::CMD_W-1:0]           cmd_i,
  input  wire logic [plst_pkg::POS_W-1:0]           position_i,
  input  wire logic signed [plst_pkg::VAL_W-1:0]    value_i,
  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [plst_pkg::STATUS_W-1:0]             status_o,
  output logic signed [plst_pkg::VAL_W-1:0]         removed_value_o,
  output logic [plst_pkg::COUNT_W-1:0]              count_o
);

  // address width, count width (must hold DEPTH itself), and a compare width
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > plst_pkg::POS_W) ? CW : plst_pkg::POS_W;
  localparam int unsigned VW = plst_pkg::VAL_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;  // fetch entry below the write slot
  localparam logic [2:0] S_INS_WR  = 3'd2;  // move it up one slot
  localparam logic [2:0] S_PLACE   = 3'd3;  // drop the new word into its slot
  localparam logic [2:0] S_RM_HEAD = 3'd4;  // capture the front entry
  localparam logic [2:0] S_RM_RD   = 3'd5;  // fetch entry above the write slot
  localparam logic [2:0] S_RM_WR   = 3'd6;  // move it down one slot
  localparam logic [2:0] S_DONE    = 3'd7;  // wait for the output register

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;     // count after the word in flight
  logic [AW-1:0]       cur_q, cur_d;         // slot being written by the shift
  logic [AW-1:0]       idx_q, idx_d;         // target slot of an insert
  logic                op_rm_q, op_rm_d;     // shift direction: 1 moves entries down
  logic [VW-1:0]       val_q, val_d;
  logic [VW-1:0]       removed_q, removed_d;
  logic [plst_pkg::STATUS_W-1:0] st_q, st_d;

  logic                          out_valid_q, out_valid_d;
  logic [plst_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [VW-1:0]                 out_removed_q, out_removed_d;
  logic [plst_pkg::COUNT_W-1:0]  out_count_q, out_count_d;

  // element memory, registered read
  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rdata_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  // shared step unit: walks the shift slot up or down
  logic [AW-1:0] step;
  assign step = op_rm_q ? (cur_q + AW'(1)) : (cur_q - AW'(1));

  // command decode
  logic [XW-1:0] pos_x, cnt_x;
  logic          pos_ok, is_full, is_empty;
  logic [AW-1:0] ins_idx;
  logic [XW-1:0] cnt_out_x;

  assign pos_x    = XW'(position_i);
  assign cnt_x    = XW'(count_q);
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);
  // position 1 always fits; otherwise it must name an existing entry
  assign pos_ok   = (pos_x == XW'(1)) || ((pos_x >= XW'(2)) && (pos_x <= cnt_x));
  assign cnt_out_x = XW'(count_q);

  always_comb begin
    case (cmd_i)
      plst_pkg::CMD_PUSH_FRONT: ins_idx = '0;
      plst_pkg::CMD_INSERT_AT:  ins_idx = AW'(pos_x - XW'(1));
      plst_pkg::CMD_APPEND:     ins_idx = AW'(count_q);
      default:                  ins_idx = '0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    cur_d         = cur_q;
    idx_d         = idx_q;
    op_rm_d       = op_rm_q;
    val_d         = val_q;
    removed_d     = removed_q;
    st_d          = st_q;
    out_valid_d   = out_valid_q & out_stall_i;
    out_status_d  = out_status_q;
    out_removed_d = out_removed_q;
    out_count_d   = out_count_q;
    rd_en         = 1'b0;
    rd_addr       = step;
    wr_en         = 1'b0;
    wr_addr       = cur_q;
    wr_data       = rdata_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d     = value_i;
          removed_d = '0;
          st_d      = plst_pkg::ST_OK;
          op_rm_d   = (cmd_i == plst_pkg::CMD_POP_FRONT);
          idx_d     = ins_idx;
          if (cmd_i == plst_pkg::CMD_POP_FRONT) begin
            if (is_empty) begin
              st_d    = plst_pkg::ST_EMPTY;
              state_d = S_DONE;
            end else begin
              count_d = count_q - CW'(1);
              cur_d   = '0;
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = S_RM_HEAD;
            end
          end else if ((cmd_i == plst_pkg::CMD_INSERT_AT) && !pos_ok) begin
            // position check wins over the full check
            st_d    = plst_pkg::ST_BADPOS;
            state_d = S_DONE;
          end else if (is_full) begin
            st_d    = plst_pkg::ST_FULL;
            state_d = S_DONE;
          end else begin
            count_d = count_q + CW'(1);
            cur_d   = AW'(count_q);
            // nothing to move when the new word goes last
            state_d = (CW'(ins_idx) == count_q) ? S_PLACE : S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        rd_en   = 1'b1;
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        wr_en   = 1'b1;
        cur_d   = step;
        state_d = (step == idx_q) ? S_PLACE : S_INS_RD;
      end
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = val_q;
        state_d = S_DONE;
      end
      S_RM_HEAD: begin
        removed_d = rdata_q;
        state_d   = (count_q == '0) ? S_DONE : S_RM_RD;
      end
      S_RM_RD: begin
        rd_en   = 1'b1;
        state_d = S_RM_WR;
      end
      S_RM_WR: begin
        wr_en   = 1'b1;
        cur_d   = step;
        state_d = (CW'(step) == count_q) ? S_DONE : S_RM_RD;
      end
      S_DONE: begin
        // hand over once the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_status_d  = st_q;
          out_removed_d = removed_q;
          out_count_d   = cnt_out_x[plst_pkg::COUNT_W-1:0];
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    cur_q         <= cur_d;
    idx_q         <= idx_d;
    op_rm_q       <= op_rm_d;
    val_q         <= val_d;
    removed_q     <= removed_d;
    st_q          <= st_d;
    out_status_q  <= out_status_d;
    out_removed_q <= out_removed_d;
    out_count_q   <= out_count_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_value_o = out_removed_q;
  assign count_o         = out_count_q;

  // count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list count above capacity");

  // an insert shift always writes above its target slot
  a_ins_above_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_WR) |-> (cur_q > idx_q))
    else $error("insert shift passed its target slot");

  // a pop shift only writes slots inside the shortened list
  a_rm_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RM_WR) |-> (CW'(cur_q) < count_q))
    else $error("pop shift wrote past the list end");

  // a word is only taken while the sequencer is idle, and it leaves idle at once
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted word did not start the sequencer");

endmodule
`default_nettype wire

@@ verif/positional_list_store_core_tb.sv @@
// testbench for positional_list_store_core: list commands checked against a shadow list
`timescale 1ns / 1ps
module positional_list_store_core_tb;

  // widths and capacity from the package
  localparam int unsigned DEPTH    = plst_pkg::DEPTH;
  localparam int unsigned CMD_W    = plst_pkg::CMD_W;
  localparam int unsigned POS_W    = plst_pkg::POS_W;
  localparam int unsigned VAL_W    = plst_pkg::VAL_W;
  localparam int unsigned STATUS_W = plst_pkg::STATUS_W;
  localparam int unsigned COUNT_W  = plst_pkg::COUNT_W;

  // run bounds; the slowest words move all but one entry of a full list
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned SHOWN_ERRORS = 10;

  // one expected result word
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [VAL_W-1:0]  removed;
    logic [COUNT_W-1:0]       count;
  } list_result_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_stall_o;
  logic [CMD_W-1:0]          cmd_i           = plst_pkg::CMD_PUSH_FRONT;
  logic [POS_W-1:0]          position_i      = '0;
  logic signed [VAL_W-1:0]   value_i         = '0;
  logic                      out_valid_o;
  logic                      out_stall_i     = 1'b0;
  logic [STATUS_W-1:0]       status_o;
  logic signed [VAL_W-1:0]   removed_value_o;
  logic [COUNT_W-1:0]        count_o;

  // shadow copy of the list contents, front first
  logic signed [VAL_W-1:0]   shadow_list[$];
  // results owed by the block, oldest first
  list_result_t              pending_results[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  // percent of cycles in which the sender idles / the receiver stalls
  int unsigned idle_pct    = 31;
  int unsigned stall_pct   = 31;

  positional_list_store_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .count_o         (count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // updates the shadow list for one command and returns what the block must answer
  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] c,
                                                  input logic [POS_W-1:0] p,
                                                  input logic signed [VAL_W-1:0] v);
    list_result_t r;
    int           slot;
    bit           pos_ok;
    r.status = plst_pkg::ST_OK;
    r.removed = '0;
    slot = 0;
    pos_ok = 1'b1;
    if (c == plst_pkg::CMD_POP_FRONT) begin
      if (shadow_list.size() == 0) r.status = plst_pkg::ST_EMPTY;
      else r.removed = shadow_list.pop_front();
    end else begin
      // position 1 is always fine; otherwise 2..count, never count+1
      if (c == plst_pkg::CMD_INSERT_AT) begin
        if (p == 1) slot = 0;
        else if (p >= 2 && p <= shadow_list.size()) slot = int'(p) - 1;
        else pos_ok = 1'b0;
      end else if (c == plst_pkg::CMD_APPEND) begin
        slot = shadow_list.size();
      end
      // a bad position wins over a full list
      if (!pos_ok) r.status = plst_pkg::ST_BADPOS;
      else if (shadow_list.size() >= DEPTH) r.status = plst_pkg::ST_FULL;
      else shadow_list.insert(slot, v);
    end
    r.count = COUNT_W'(shadow_list.size());
    return r;
  endfunction

  // random value, with the sign extremes, zero and minus one showing up often
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly a position that lands inside the list, sometimes anything in range
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(9) < 8 && shadow_list.size() > 0)
      return POS_W'($urandom_range(shadow_list.size(), 1));
    return POS_W'($urandom_range(DEPTH, 0));
  endfunction

  function automatic logic [CMD_W-1:0] pick_insert_cmd();
    case ($urandom_range(2))
      0: return plst_pkg::CMD_PUSH_FRONT;
      1: return plst_pkg::CMD_INSERT_AT;
      default: return plst_pkg::CMD_APPEND;
    endcase
  endfunction

  // drives one command word and returns at the edge that takes it
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                           input logic signed [VAL_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    position_i <= p;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(apply_list_cmd(c, p, v));
  endtask

  task automatic flag_error(input string what, input list_result_t want);
    fail_count++;
    if (fail_count <= SHOWN_ERRORS)
      $display("%0t %s: want status %0d removed %0d count %0d,%s%0d removed %0d count %0d",
               $time, what, want.status, want.removed, want.count, " got status ",
               status_o, removed_value_o, count_o);
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        want = '0;
        flag_error("result word with nothing pending", want);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || removed_value_o !== want.removed ||
            count_o !== want.count)
          flag_error("result word mismatch", want);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // empty list, position rules at small counts, value extremes, draining to empty
  task automatic test_empty_and_positions();
    int n;
    send_word(plst_pkg::CMD_POP_FRONT, POS_W'($urandom_range(DEPTH, 0)), pick_value());
    send_word(plst_pkg::CMD_INSERT_AT, 7'd0, 32'h1234_5678);      // position zero
    send_word(plst_pkg::CMD_INSERT_AT, 7'd1, 32'h8000_0000);      // position one, empty list
    send_word(plst_pkg::CMD_INSERT_AT, 7'd2, 32'h0bad_0bad);      // count plus one
    send_word(plst_pkg::CMD_PUSH_FRONT, POS_W'(DEPTH), 32'h7fff_ffff);
    send_word(plst_pkg::CMD_APPEND, 7'd0, '1);
    send_word(plst_pkg::CMD_INSERT_AT, 7'd2, 32'h5555_5555);
    send_word(plst_pkg::CMD_INSERT_AT, 7'd4, 32'haaaa_aaaa);      // position equal to count
    send_word(plst_pkg::CMD_INSERT_AT, 7'd6, 32'h0bad_0bad);      // count plus one again
    send_word(plst_pkg::CMD_INSERT_AT, POS_W'(DEPTH), 32'h0bad_0bad);
    send_word(plst_pkg::CMD_INSERT_AT, 7'd5, '0);
    send_word(plst_pkg::CMD_APPEND, 7'd1, 32'h0000_0001);
    n = shadow_list.size();
    repeat (n + 1)
      send_word(plst_pkg::CMD_POP_FRONT, POS_W'($urandom_range(DEPTH, 0)), pick_value());
  endtask

  // grow to a full list, poke it while full, then drain past empty
  task automatic test_fill_and_drain(input int unsigned idle_level);
    logic [CMD_W-1:0] c;
    idle_pct  = idle_level;
    stall_pct = idle_level;
    while (shadow_list.size() < DEPTH) begin
      c = pick_insert_cmd();
      send_word(c, pick_position(), pick_value());
    end
    send_word(plst_pkg::CMD_PUSH_FRONT, pick_position(), pick_value());
    send_word(plst_pkg::CMD_APPEND, pick_position(), pick_value());
    send_word(plst_pkg::CMD_INSERT_AT, 7'd1, pick_value());
    send_word(plst_pkg::CMD_INSERT_AT, POS_W'(DEPTH), pick_value());
    send_word(plst_pkg::CMD_INSERT_AT, 7'd0, pick_value());   // bad position reported over full
    while (shadow_list.size() > 0)
      send_word(plst_pkg::CMD_POP_FRONT, pick_position(), pick_value());
    send_word(plst_pkg::CMD_POP_FRONT, pick_position(), pick_value());
    idle_pct  = 31;
    stall_pct = 31;
  endtask

  // random walk of the count, drifting up or down so both ends get visited
  task automatic test_random_mix(input int unsigned n_words);
    bit               growing;
    int unsigned      roll;
    logic [CMD_W-1:0] c;
    growing = 1'b1;
    repeat (n_words) begin
      if (shadow_list.size() >= DEPTH) growing = 1'b0;
      else if (shadow_list.size() == 0) growing = 1'b1;
      else if ($urandom_range(47) == 0) growing = !growing;
      roll = $urandom_range(99);
      if (roll < 10) c = CMD_W'($urandom_range(3));
      else if ((roll < 75) == growing) c = pick_insert_cmd();
      else c = plst_pkg::CMD_POP_FRONT;
      send_word(c, pick_position(), pick_value());
    end
  endtask

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : run_tests
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_positions();
    test_fill_and_drain(31);
    // long stretch with no idling on either side
    test_fill_and_drain(0);
    test_random_mix(950);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
